>>> sv/ors_pkg.sv
// ----------------------------------------------------------------------------
// ors_pkg: shared types and constants of the 1-Wire ROM search engine
// Word formats, status and item codes, and widths of the search state.
// ----------------------------------------------------------------------------
package ors_pkg;

    // ROM geometry
    localparam int ROM_BITS = 64;
    localparam int IDX_W    = $clog2(ROM_BITS);
    localparam int POS_W    = IDX_W + 1;

    localparam logic [IDX_W-1:0] ROM_LAST     = IDX_W'(ROM_BITS - 1);
    localparam logic [POS_W-1:0] FAMILY_LIMIT = POS_W'(9);

    // ROM code CRC-8, reflected form of x^8 + x^5 + x^4 + 1
    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BIT   = 2'd1,
        KIND_CLEAR = 2'd2
    } ors_kind_t;

    typedef enum logic [3:0] {
        ST_ACCEPT   = 4'd0,
        ST_STARTED  = 4'd1,
        ST_FOUND    = 4'd2,
        ST_NOPRES   = 4'd3,
        ST_NORESP   = 4'd4,
        ST_CRCERR   = 4'd5,
        ST_COMPLETE = 4'd6,
        ST_IGNORED  = 4'd7,
        ST_CLEARED  = 4'd8
    } ors_status_t;

    typedef struct packed {
        ors_kind_t kind;
        logic      presence;
        logic      id_bit;
        logic      cmp_bit;
    } ors_item_t;

    typedef struct packed {
        ors_status_t         status;
        logic                write_bit;
        logic [ROM_BITS-1:0] rom_value;
        logic                last_found;
        logic [3:0]          family_mark;
    } ors_result_t;

endpackage

>>> sv/onewire_rom_search.sv
// ----------------------------------------------------------------------------
// onewire_rom_search: 1-Wire Search ROM engine
// Input register, decision core with search state, and result register.
// ----------------------------------------------------------------------------
// The engine takes one word per clock while not stalled and returns exactly
// one result word for each, through the input and then the result register.
// Throughput is one word per cycle unless stalled; the only sequential
// dependency is the core search state, updated in the same cycle the word
// moves from the input register into the result register. A start word
// opens a pass, 64 bit words follow with the direction bit returned for
// each, and the 64th returns found or crc error. ROM, discrepancy markers
// and the last-device flag persist across passes until a clear word.
module onewire_rom_search
    import ors_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          kind,
    input  logic                presence,
    input  logic                id_bit,
    input  logic                cmp_bit,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          status,
    output logic                write_bit,
    output logic [ROM_BITS-1:0] rom_value,
    output logic                last_found,
    output logic [3:0]          family_mark
);

    logic        item_valid;
    ors_item_t   item;
    logic        advance;
    ors_result_t result;
    ors_result_t out_word;

    ors_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .presence   (presence),
        .id_bit     (id_bit),
        .cmp_bit    (cmp_bit),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ors_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .result (result)
    );

    ors_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

    // Unpack the result word
    assign status      = out_word.status;
    assign write_bit   = out_word.write_bit;
    assign rom_value   = out_word.rom_value;
    assign last_found  = out_word.last_found;
    assign family_mark = out_word.family_mark;

endmodule

>>> sv/ors_in_stage.sv
// ----------------------------------------------------------------------------
// ors_in_stage: input register of the search engine
// Captures one input word per cycle and holds it while the result register cannot take it.
// ----------------------------------------------------------------------------
module ors_in_stage
    import ors_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic       presence,
    input  logic       id_bit,
    input  logic       cmp_bit,
    input  logic       advance,
    output logic       item_valid,
    output ors_item_t  item
);

    logic      valid_reg;
    logic      valid_next;
    ors_item_t item_reg;
    logic      load;

    // Take a new word when the register is empty or drains this cycle
    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.kind     <= ors_kind_t'(kind);
            item_reg.presence <= presence;
            item_reg.id_bit   <= id_bit;
            item_reg.cmp_bit  <= cmp_bit;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> sv/ors_core.sv
// ----------------------------------------------------------------------------
// ors_core: search state and per-word decision logic
// Holds the ROM, discrepancy markers and serial CRC, and forms one result.
// ----------------------------------------------------------------------------
module ors_core
    import ors_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  ors_item_t   item,
    output ors_result_t result
);

    logic [ROM_BITS-1:0] rom_reg,       rom_next;
    logic [POS_W-1:0]    last_disc_reg, last_disc_next;
    logic [3:0]          family_reg,    family_next;
    logic                done_reg,      done_next;
    logic [IDX_W-1:0]    bit_idx_reg,   bit_idx_next;
    logic [POS_W-1:0]    zero_pos_reg,  zero_pos_next;
    logic [7:0]          crc_reg,       crc_next;
    logic                active_reg,    active_next;

    logic [POS_W-1:0] pos;
    logic             dir;
    logic [7:0]       crc_step;

    // One step of the serial CRC, least significant bit first
    function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic b);
        logic [7:0] shifted;
        shifted = {1'b0, crc[7:1]};
        return (crc[0] ^ b) ? (shifted ^ CRC_POLY) : shifted;
    endfunction

    assign pos      = {1'b0, bit_idx_reg} + POS_W'(1);
    assign crc_step = crc_bit(crc_reg, dir);

    // Pick the direction bit for the current slot
    always_comb
    begin
        if (item.id_bit != item.cmp_bit)
        begin
            dir = item.id_bit;
        end
        else if (pos < last_disc_reg)
        begin
            dir = rom_reg[bit_idx_reg];
        end
        else
        begin
            dir = (pos == last_disc_reg);
        end
    end

    // Decode the word and form next state and result
    always_comb
    begin
        rom_next       = rom_reg;
        last_disc_next = last_disc_reg;
        family_next    = family_reg;
        done_next      = done_reg;
        bit_idx_next   = bit_idx_reg;
        zero_pos_next  = zero_pos_reg;
        crc_next       = crc_reg;
        active_next    = active_reg;

        result             = '0;
        result.status      = ST_IGNORED;

        case (item.kind)
            KIND_START:
            begin
                if (done_reg)
                begin
                    active_next   = 1'b0;
                    result.status = ST_COMPLETE;
                end
                else if (!item.presence)
                begin
                    active_next   = 1'b0;
                    result.status = ST_NOPRES;
                end
                else
                begin
                    bit_idx_next  = '0;
                    zero_pos_next = '0;
                    crc_next      = '0;
                    active_next   = 1'b1;
                    result.status = ST_STARTED;
                end
            end
            KIND_BIT:
            begin
                if (active_reg)
                begin
                    if (item.id_bit && item.cmp_bit)
                    begin
                        active_next   = 1'b0;
                        result.status = ST_NORESP;
                    end
                    else
                    begin
                        // Record a zero taken at a discrepancy
                        if ((item.id_bit == item.cmp_bit) && !dir)
                        begin
                            zero_pos_next = pos;
                            if (pos < FAMILY_LIMIT)
                            begin
                                family_next = pos[3:0];
                            end
                        end
                        rom_next[bit_idx_reg] = dir;
                        crc_next              = crc_step;
                        bit_idx_next          = bit_idx_reg + IDX_W'(1);
                        result.write_bit      = dir;
                        result.status         = ST_ACCEPT;

                        // Close the pass on the last ROM bit
                        if (bit_idx_reg == ROM_LAST)
                        begin
                            active_next = 1'b0;
                            if (crc_step == 8'h00)
                            begin
                                last_disc_next     = zero_pos_next;
                                done_next          = (zero_pos_next == '0) ? 1'b1 : done_reg;
                                result.status      = ST_FOUND;
                                result.rom_value   = rom_next;
                                result.last_found  = done_next;
                                result.family_mark = family_next;
                            end
                            else
                            begin
                                result.status = ST_CRCERR;
                            end
                        end
                    end
                end
            end
            KIND_CLEAR:
            begin
                rom_next       = '0;
                last_disc_next = '0;
                family_next    = '0;
                done_next      = 1'b0;
                bit_idx_next   = '0;
                zero_pos_next  = '0;
                crc_next       = '0;
                active_next    = 1'b0;
                result.status  = ST_CLEARED;
            end
            default:
            begin
                result.status = ST_IGNORED;
            end
        endcase
    end

    // Advance the search state when the word moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg       <= '0;
            last_disc_reg <= '0;
            family_reg    <= '0;
            done_reg      <= 1'b0;
            bit_idx_reg   <= '0;
            zero_pos_reg  <= '0;
            crc_reg       <= '0;
            active_reg    <= 1'b0;
        end
        else if (fire)
        begin
            rom_reg       <= rom_next;
            last_disc_reg <= last_disc_next;
            family_reg    <= family_next;
            done_reg      <= done_next;
            bit_idx_reg   <= bit_idx_next;
            zero_pos_reg  <= zero_pos_next;
            crc_reg       <= crc_next;
            active_reg    <= active_next;
        end
    end

    // A pass never runs once the last device is known
    assert property (@(posedge clk) disable iff (!rst_n) !(active_reg && done_reg))
        else $error("pass running after search complete");

    // Found or CRC error only on the last ROM bit
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && (result.status == ST_FOUND || result.status == ST_CRCERR)
        |-> bit_idx_reg == ROM_LAST)
        else $error("pass closed before the last ROM bit");

    // An accepted bit advances the position by one
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.status == ST_ACCEPT
        |=> bit_idx_reg == $past(bit_idx_reg) + IDX_W'(1))
        else $error("bit position did not advance");

    // The last discrepancy stays within the ROM
    assert property (@(posedge clk) disable iff (!rst_n)
        last_disc_reg <= POS_W'(ROM_BITS))
        else $error("last discrepancy out of range");

endmodule

>>> sv/ors_out_stage.sv
// ----------------------------------------------------------------------------
// ors_out_stage: result register of the search engine
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module ors_out_stage
    import ors_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  ors_result_t result,
    output logic        advance,
    output logic        out_valid,
    input  logic        out_stall,
    output ors_result_t out_word
);

    logic        valid_reg;
    logic        valid_next;
    ors_result_t word_reg;

    // Load when empty or when the held word leaves this cycle
    assign advance    = item_valid && (!valid_reg || !out_stall);
    assign valid_next = advance ? 1'b1 : ((valid_reg && !out_stall) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> tb/onewire_rom_search_check.sv
// ----------------------------------------------------------------------------
// onewire_rom_search_check: result checker for the 1-Wire ROM search engine
// Watches both channels, runs its own copy of the search state on every
// accepted input word and compares each accepted result word, field by
// field, with the oldest expected word.
// ----------------------------------------------------------------------------
module onewire_rom_search_check
    import ors_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          kind,
    input  logic                presence,
    input  logic                id_bit,
    input  logic                cmp_bit,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [3:0]          status,
    input  logic                write_bit,
    input  logic [ROM_BITS-1:0] rom_value,
    input  logic                last_found,
    input  logic [3:0]          family_mark,
    output int                  mismatches,
    output int                  open_words
);

    // search state as the engine should hold it
    logic [ROM_BITS-1:0] rom_q;
    logic [POS_W-1:0]    last_disc_q;
    logic [3:0]          family_disc_q;
    logic                done_q;
    logic [POS_W-1:0]    bit_pos_q;
    logic [POS_W-1:0]    zero_pos_q;
    logic [7:0]          crc_q;
    logic                active_q;

    ors_result_t expected_q[$];
    int          fail_total;

    // one byte through the reflected ROM code CRC-8
    function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // advance the search state by one input word and return its result word
    function automatic ors_result_t search_step(logic [1:0] k, logic p, logic a, logic c);
        ors_result_t res;
        logic [IDX_W-1:0] idx;
        logic             dir;
        res        = '0;
        res.status = ST_IGNORED;
        case (k)
            KIND_START:
            begin
                if (done_q)
                begin
                    active_q   = 1'b0;
                    res.status = ST_COMPLETE;
                end
                else if (!p)
                begin
                    active_q   = 1'b0;
                    res.status = ST_NOPRES;
                end
                else
                begin
                    bit_pos_q  = POS_W'(1);
                    zero_pos_q = '0;
                    crc_q      = '0;
                    active_q   = 1'b1;
                    res.status = ST_STARTED;
                end
            end
            KIND_BIT:
            begin
                if (active_q && a && c)
                begin
                    active_q   = 1'b0;
                    res.status = ST_NORESP;
                end
                else if (active_q)
                begin
                    idx = bit_pos_q[IDX_W-1:0] - IDX_W'(1);
                    if (a != c)
                        dir = a;
                    else
                    begin
                        // discrepancy: follow the old path, then branch at the last one
                        if (bit_pos_q < last_disc_q)
                            dir = rom_q[idx];
                        else
                            dir = (bit_pos_q == last_disc_q);
                        if (!dir)
                        begin
                            zero_pos_q = bit_pos_q;
                            if (zero_pos_q < FAMILY_LIMIT)
                                family_disc_q = zero_pos_q[3:0];
                        end
                    end
                    rom_q[idx]    = dir;
                    res.write_bit = dir;
                    if (idx[2:0] == 3'd7)
                        crc_q = crc8_byte(crc_q, rom_q[{idx[IDX_W-1:3], 3'b000} +: 8]);
                    bit_pos_q  = bit_pos_q + POS_W'(1);
                    res.status = ST_ACCEPT;
                    if (idx == ROM_LAST)
                    begin
                        active_q = 1'b0;
                        if (crc_q == 8'd0)
                        begin
                            last_disc_q = zero_pos_q;
                            if (last_disc_q == '0)
                                done_q = 1'b1;
                            res.status      = ST_FOUND;
                            res.rom_value   = rom_q;
                            res.last_found  = done_q;
                            res.family_mark = family_disc_q;
                        end
                        else
                            res.status = ST_CRCERR;
                    end
                end
            end
            KIND_CLEAR:
            begin
                rom_q         = '0;
                last_disc_q   = '0;
                family_disc_q = '0;
                done_q        = 1'b0;
                bit_pos_q     = POS_W'(1);
                zero_pos_q    = '0;
                crc_q         = '0;
                active_q      = 1'b0;
                res.status    = ST_CLEARED;
            end
            default:
                res.status = ST_IGNORED;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ors_result_t want;
        ors_result_t got;
        if (!rst_n)
        begin
            rom_q         = '0;
            last_disc_q   = '0;
            family_disc_q = '0;
            done_q        = 1'b0;
            bit_pos_q     = POS_W'(1);
            zero_pos_q    = '0;
            crc_q         = '0;
            active_q      = 1'b0;
            expected_q.delete();
            fail_total    = 0;
            mismatches   <= 0;
            open_words   <= 0;
        end
        else
        begin
            // predict on every accepted input word
            if (in_valid && !in_stall)
                expected_q.push_back(search_step(kind, presence, id_bit, cmp_bit));

            // compare every accepted result word with the oldest prediction
            if (out_valid && !out_stall)
            begin
                got.status      = ors_status_t'(status);
                got.write_bit   = write_bit;
                got.rom_value   = rom_value;
                got.last_found  = last_found;
                got.family_mark = family_mark;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result word with none expected, status %0d",
                             $time, status);
                    fail_total++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        fail_total++;
                    end
                    if (got.write_bit !== want.write_bit)
                    begin
                        $display("%0t: write_bit expected %0d got %0d",
                                 $time, want.write_bit, got.write_bit);
                        fail_total++;
                    end
                    if (got.rom_value !== want.rom_value)
                    begin
                        $display("%0t: rom_value expected %h got %h",
                                 $time, want.rom_value, got.rom_value);
                        fail_total++;
                    end
                    if (got.last_found !== want.last_found)
                    begin
                        $display("%0t: last_found expected %0d got %0d",
                                 $time, want.last_found, got.last_found);
                        fail_total++;
                    end
                    if (got.family_mark !== want.family_mark)
                    begin
                        $display("%0t: family_mark expected %0d got %0d",
                                 $time, want.family_mark, got.family_mark);
                        fail_total++;
                    end
                end
            end
            mismatches <= fail_total;
            open_words <= expected_q.size();
        end
    end

endmodule

>>> tb/onewire_rom_search_tb.sv
// ----------------------------------------------------------------------------
// onewire_rom_search_tb: testbench of the 1-Wire ROM search engine
// Drives directed words, then emulated device buses that are enumerated pass
// by pass, streamed passes with good and bad CRC, and random noise words,
// with random gaps on the input and random stalls on the output. The checker
// beside the engine predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module onewire_rom_search_tb;
    import ors_pkg::*;

    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam int         WORD_TARGET = 900;
    localparam int         CYCLE_LIMIT = 500000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          kind = KIND_START;
    logic                presence = 1'b0;
    logic                id_bit = 1'b0;
    logic                cmp_bit = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [3:0]          status;
    logic                write_bit;
    logic [ROM_BITS-1:0] rom_value;
    logic                last_found;
    logic [3:0]          family_mark;

    int   mismatches;
    int   open_words;
    int   words_sent = 0;
    int   words_back = 0;
    int   cycle_count = 0;
    int   stall_left = 0;
    logic [3:0] last_status = ST_IGNORED;
    logic       last_wbit = 1'b0;
    logic       dir_log[$];
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;

    onewire_rom_search uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .presence    (presence),
        .id_bit      (id_bit),
        .cmp_bit     (cmp_bit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .write_bit   (write_bit),
        .rom_value   (rom_value),
        .last_found  (last_found),
        .family_mark (family_mark)
    );

    onewire_rom_search_check search_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .presence    (presence),
        .id_bit      (id_bit),
        .cmp_bit     (cmp_bit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .write_bit   (write_bit),
        .rom_value   (rom_value),
        .last_found  (last_found),
        .family_mark (family_mark),
        .mismatches  (mismatches),
        .open_words  (open_words)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("onewire_rom_search_tb: FAIL");
            $finish;
        end
    end

    // stall the result channel: mostly short bursts, now and then a long one
    always @(posedge clk or negedge rst_n)
    begin : stall_gen
        int r;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (rx_calm || r < 70)
                out_stall <= 1'b0;
            else
            begin
                out_stall  <= 1'b1;
                stall_left <= (r > 96) ? $urandom_range(8, 25) : $urandom_range(0, 2);
            end
        end
    end

    // track returned words so bus emulation can follow the chosen direction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            words_back  <= words_back + 1;
            last_status <= status;
            last_wbit   <= write_bit;
            dir_log.push_back(write_bit);
        end
    end

    function automatic logic coin();
        return logic'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // present one word after a random gap and hold it until accepted
    task automatic send_word(logic [1:0] k, logic p, logic a, logic c);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 55)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 2);
        else if (r < 97)
            gap = $urandom_range(3, 6);
        else
            gap = $urandom_range(10, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        presence <= p;
        id_bit   <= a;
        cmp_bit  <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // drop valid and wait for every result word to come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_back != words_sent)
            @(posedge clk);
    endtask

    // enumerate a bus of devices with valid ROM codes, one bit per round trip
    task automatic enumerate_bus(int n_dev);
        logic [63:0] dev_rom[4];
        logic [3:0]  alive;
        logic [7:0]  crc;
        logic        idb;
        logic        cmpb;
        int          cut;
        int          abort_at;
        bit          finished;
        finished = 1'b0;
        for (int i = 0; i < n_dev; i++)
        begin
            dev_rom[i] = {$urandom, $urandom};
            // share a random prefix so discrepancies land anywhere, family bits too
            if (i > 0)
            begin
                cut = $urandom_range(0, 56);
                for (int b = 0; b < cut; b++)
                    dev_rom[i][b] = dev_rom[0][b];
            end
            crc = '0;
            for (int j = 0; j < 7; j++)
                crc = crc8_byte(crc, dev_rom[i][8*j +: 8]);
            dev_rom[i][63:56] = crc;
        end
        send_word(KIND_CLEAR, coin(), coin(), coin());
        for (int pass_no = 0; pass_no < 2 * n_dev + 4 && !finished; pass_no++)
        begin
            if ($urandom_range(0, 5) == 0)
                send_word(KIND_START, 1'b0, coin(), coin());
            send_word(KIND_START, 1'b1, coin(), coin());
            wait_drain();
            if (last_status != ST_STARTED)
                finished = 1'b1;
            else
            begin
                alive    = 4'((1 << n_dev) - 1);
                abort_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : 64;
                for (int b = 0; b < abort_at; b++)
                begin
                    // wired-AND of the bit and of its complement
                    idb  = 1'b1;
                    cmpb = 1'b1;
                    for (int i = 0; i < n_dev; i++)
                    begin
                        if (alive[i])
                        begin
                            if (dev_rom[i][b])
                                cmpb = 1'b0;
                            else
                                idb = 1'b0;
                        end
                    end
                    send_word(KIND_BIT, coin(), idb, cmpb);
                    wait_drain();
                    for (int i = 0; i < n_dev; i++)
                    begin
                        if (dev_rom[i][b] != last_wbit)
                            alive[i] = 1'b0;
                    end
                end
                // cut the pass short: devices vanish or a new reset comes
                if (abort_at < 64)
                begin
                    if (coin())
                        send_word(KIND_BIT, coin(), 1'b1, 1'b1);
                    else
                        send_word(KIND_START, 1'b1, coin(), coin());
                end
            end
        end
        send_word(KIND_START, coin(), coin(), coin());
    endtask

    // stream a whole pass back to back; close it with a good or a bad CRC byte
    task automatic stream_pass(bit bad_crc);
        logic [63:0] path;
        logic [7:0]  crc;
        logic        a;
        send_word(KIND_START, 1'b1, coin(), coin());
        wait_drain();
        if (last_status != ST_STARTED)
        begin
            send_word(KIND_CLEAR, coin(), coin(), coin());
            send_word(KIND_START, 1'b1, coin(), coin());
            wait_drain();
        end
        dir_log.delete();
        for (int b = 0; b < 56; b++)
        begin
            a = coin();
            if ($urandom_range(0, 99) < 72)
                send_word(KIND_BIT, coin(), a, ~a);
            else
                send_word(KIND_BIT, coin(), 1'b0, 1'b0);
        end
        wait_drain();
        path = '0;
        for (int b = 0; b < 56 && b < dir_log.size(); b++)
            path[b] = dir_log[b];
        crc = '0;
        for (int j = 0; j < 7; j++)
            crc = crc8_byte(crc, path[8*j +: 8]);
        if (bad_crc)
            crc = crc ^ 8'($urandom_range(1, 255));
        for (int j = 0; j < 8; j++)
            send_word(KIND_BIT, coin(), crc[j], ~crc[j]);
    endtask

    // random words of every kind, including spare codes and dead slots
    task automatic noise_burst(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                send_word(KIND_START, coin(), coin(), coin());
            else if (r < 82)
                send_word(KIND_BIT, coin(), coin(), coin());
            else if (r < 87)
                send_word(KIND_CLEAR, coin(), coin(), coin());
            else
                send_word(KIND_SPARE, coin(), coin(), coin());
        end
    endtask

    initial
    begin : stimulus
        int r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle engine, spare code, presence handling, short pass
        send_word(KIND_BIT, 1'b0, 1'b0, 1'b1);
        send_word(KIND_SPARE, 1'b1, 1'b1, 1'b1);
        send_word(KIND_START, 1'b0, 1'b1, 1'b1);
        send_word(KIND_START, 1'b1, 1'b0, 1'b0);
        send_word(KIND_BIT, 1'b1, 1'b1, 1'b0);
        send_word(KIND_BIT, 1'b0, 1'b0, 1'b1);
        send_word(KIND_BIT, 1'b1, 1'b0, 1'b0);
        send_word(KIND_BIT, 1'b0, 1'b1, 1'b1);
        send_word(KIND_BIT, 1'b1, 1'b0, 1'b0);
        send_word(KIND_START, 1'b1, 1'b1, 1'b0);
        send_word(KIND_START, 1'b1, 1'b0, 1'b1);
        send_word(KIND_BIT, 1'b0, 1'b0, 1'b0);
        send_word(KIND_CLEAR, 1'b1, 1'b1, 1'b1);
        send_word(KIND_BIT, 1'b1, 1'b1, 1'b0);
        send_word(KIND_SPARE, 1'b0, 1'b0, 1'b0);
        send_word(KIND_CLEAR, 1'b0, 1'b0, 1'b0);

        // random: enumerations, streamed passes and noise
        while (words_sent < WORD_TARGET)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 40)
                enumerate_bus(($urandom_range(0, 4) == 0) ? 4 : $urandom_range(1, 3));
            else if (r < 80)
                stream_pass(r >= 70);
            else
                noise_burst($urandom_range(5, 30));
        end

        wait_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && open_words == 0)
            $display("onewire_rom_search_tb: PASS");
        else
            $display("onewire_rom_search_tb: FAIL");
        $finish;
    end

endmodule
